/* design/assert_macros.svh */
// Assertion macros shared by the design files.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define DST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define DST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/dst_pkg.sv */
// Shared types and constants for the summer-time tracker.
// No dependencies; used by dst_last_sunday and dst_switch_tracker_top.
package dst_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;

  localparam int CENT_W  = 8;   // year / 100, up to 163
  localparam int YY_W    = 7;   // year % 100
  localparam int N_W     = 11;  // weekday sum before mod 7

  // year / 100 as (year * RECIP_100) >> RECIP_SHIFT, exact over 14-bit years
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

  localparam logic [MONTH_W-1:0] MON_MARCH   = 4'd3;
  localparam logic [MONTH_W-1:0] MON_OCTOBER = 4'd10;

  // month terms of the weekday formula, 31st-of-month offset folded in
  localparam logic [N_W-1:0] MTERM_MARCH   = 11'd2;
  localparam logic [N_W-1:0] MTERM_OCTOBER = 11'd20;
  localparam logic [N_W-1:0] DAY_OFFSET    = 11'd37;

  localparam logic [DAY_W-1:0]  LAST_DAY    = 5'd31;
  localparam logic [2:0]        WD_SUNDAY   = 3'd6;
  localparam logic [HOUR_W-1:0] SPRING_HOUR = 5'd2;
  localparam logic [HOUR_W-1:0] FALL_HOUR   = 5'd3;
  localparam logic [HOUR_W:0]   HOURS_DAY   = 6'd24;
  localparam logic [HOUR_W:0]   HOURS_2DAY  = 6'd48;

  typedef struct packed {
    logic adv2;   // stage 1 moves into stage 2
    logic adv3;   // stage 2 moves into stage 3
  } stage_ctl_t;

endpackage

/* design/dst_last_sunday.sv */
// Two-stage last-Sunday calculator for March or October of a given year.
// Depends on dst_pkg; stage advance comes from dst_switch_tracker_top.
module dst_last_sunday (
  input  logic                       clk,
  input  dst_pkg::stage_ctl_t        ctl,
  input  logic [dst_pkg::YEAR_W-1:0] year_i,
  input  logic                       is_oct_i,
  output logic [dst_pkg::DAY_W-1:0]  last_sun_o
);
  import dst_pkg::*;

  logic [YEAR_W+RECIP_W-1:0] prod;
  logic [CENT_W-1:0]         cent_r;
  logic [YEAR_W-1:0]         year2_r;
  logic [YEAR_W-1:0]         yy_full;
  logic [YY_W-1:0]           yy;
  logic [N_W-1:0]            n_nxt;
  logic [N_W-1:0]            n_r;
  logic [4:0]                fold1;
  logic [3:0]                fold2;
  logic [2:0]                wday;
  logic [2:0]                back;

  // stage 2: century by reciprocal multiply
  assign prod = (YEAR_W+RECIP_W)'(year_i) * (YEAR_W+RECIP_W)'(RECIP_100);

  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      cent_r  <= prod[RECIP_SHIFT +: CENT_W];
      year2_r <= year_i;
    end
  end

  // stage 3: weekday sum
  assign yy_full = year2_r - (YEAR_W'(cent_r) * YEAR_W'(100));
  assign yy      = yy_full[YY_W-1:0];
  assign n_nxt   = (is_oct_i ? MTERM_OCTOBER : MTERM_MARCH)
                 + N_W'(yy) + N_W'(yy >> 2)
                 + N_W'(cent_r >> 2)
                 + N_W'(cent_r) + (N_W'(cent_r) << 2)
                 + DAY_OFFSET;

  always_ff @(posedge clk) begin
    if (ctl.adv3) begin
      n_r <= n_nxt;
    end
  end

  // mod 7 by folding octal digits, since 8 is 1 mod 7
  assign fold1 = 5'(n_r[2:0]) + 5'(n_r[5:3]) + 5'(n_r[8:6]) + 5'(n_r[10:9]);
  assign fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
  assign wday  = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

  // days from the 31st back to its Sunday
  assign back       = (wday == WD_SUNDAY) ? 3'd0 : 3'(wday + 3'd1);
  assign last_sun_o = LAST_DAY - DAY_W'(back);

endmodule

/* design/dst_switch_tracker_top.sv */
// Summer/winter time tracker: a pipelined path from request to result.
// Throughput one request per cycle unless out_ready holds the pipeline; stages
// 2-3 compute the weekday, the output stage holds the summer flag and the output register.
// A held result does not block intake while upstream stages have room.
// Synchronous active-low reset empties the pipeline and sets summer time.
`include "assert_macros.svh"

module dst_switch_tracker_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dst_pkg::YEAR_W-1:0]  in_year,
  input  logic [dst_pkg::MONTH_W-1:0] in_month,
  input  logic [dst_pkg::DAY_W-1:0]   in_day,
  input  logic [dst_pkg::HOUR_W-1:0]  in_hour,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_summer_time,
  output logic                        out_changed,
  output logic [dst_pkg::HOUR_W-1:0]  out_corrected_hour
);
  import dst_pkg::*;

  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt, ov_r, ov_nxt;
  logic in_acc, adv_out;
  stage_ctl_t ctl;

  logic [YEAR_W-1:0]  s1_year_r;
  logic [MONTH_W-1:0] s1_month_r, s2_month_r, s3_month_r;
  logic [DAY_W-1:0]   s1_day_r, s2_day_r, s3_day_r;
  logic [HOUR_W-1:0]  s1_hour_r, s2_hour_r, s3_hour_r;

  logic [DAY_W-1:0]   last_sun;
  logic               flag_r, flag_nxt;
  logic               is_mar;
  logic [HOUR_W:0]    fwd, bwd;
  logic [HOUR_W-1:0]  corr;

  logic               out_summer_r, out_changed_r;
  logic [HOUR_W-1:0]  out_hour_r;

  assign adv_out  = v3_r && (!ov_r || out_ready);
  assign ctl.adv3 = v2_r && (!v3_r || adv_out);
  assign ctl.adv2 = v1_r && (!v2_r || ctl.adv3);
  assign in_ready = !v1_r || ctl.adv2;
  assign in_acc   = in_valid && in_ready;

  assign v1_nxt = in_acc   ? 1'b1 : (ctl.adv2 ? 1'b0 : v1_r);
  assign v2_nxt = ctl.adv2 ? 1'b1 : (ctl.adv3 ? 1'b0 : v2_r);
  assign v3_nxt = ctl.adv3 ? 1'b1 : (adv_out  ? 1'b0 : v3_r);
  assign ov_nxt = adv_out  ? 1'b1 : ((ov_r && out_ready) ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      ov_r   <= 1'b0;
      flag_r <= 1'b1;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      ov_r <= ov_nxt;
      if (adv_out) begin
        flag_r <= flag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_year_r  <= in_year;
      s1_month_r <= in_month;
      s1_day_r   <= in_day;
      s1_hour_r  <= in_hour;
    end
    if (ctl.adv2) begin
      s2_month_r <= s1_month_r;
      s2_day_r   <= s1_day_r;
      s2_hour_r  <= s1_hour_r;
    end
    if (ctl.adv3) begin
      s3_month_r <= s2_month_r;
      s3_day_r   <= s2_day_r;
      s3_hour_r  <= s2_hour_r;
    end
    if (adv_out) begin
      out_summer_r  <= flag_nxt;
      out_changed_r <= flag_nxt != flag_r;
      out_hour_r    <= corr;
    end
  end

  dst_last_sunday u_last_sun (
    .clk        (clk),
    .ctl        (ctl),
    .year_i     (s1_year_r),
    .is_oct_i   (s2_month_r == MON_OCTOBER),
    .last_sun_o (last_sun)
  );

  assign is_mar = (s3_month_r == MON_MARCH);

  always_comb begin
    flag_nxt = flag_r;
    if (s3_month_r > MON_MARCH && s3_month_r < MON_OCTOBER) begin
      flag_nxt = 1'b1;
    end else if (s3_month_r != MON_MARCH && s3_month_r != MON_OCTOBER) begin
      flag_nxt = 1'b0;
    end else if (s3_day_r > last_sun) begin
      flag_nxt = is_mar;
    end else if (s3_day_r < last_sun) begin
      flag_nxt = !is_mar;
    end else if (is_mar) begin
      flag_nxt = s3_hour_r >= SPRING_HOUR;
    end else if (s3_hour_r >= FALL_HOUR) begin
      flag_nxt = 1'b0;
    end else if (s3_hour_r < SPRING_HOUR) begin
      flag_nxt = 1'b1;
    end
    // hour two of the switch day in October: keep the current flag
  end

  // wrap the shifted hour mod 24
  always_comb begin
    fwd = (HOUR_W+1)'(s3_hour_r) + 6'd1;
    bwd = (HOUR_W+1)'(s3_hour_r) + 6'd23;
    if (fwd >= HOURS_DAY) begin
      fwd = fwd - HOURS_DAY;
    end
    if (bwd >= HOURS_2DAY) begin
      bwd = bwd - HOURS_2DAY;
    end else if (bwd >= HOURS_DAY) begin
      bwd = bwd - HOURS_DAY;
    end
    if (flag_nxt == flag_r) begin
      corr = s3_hour_r;
    end else if (flag_nxt) begin
      corr = fwd[HOUR_W-1:0];
    end else begin
      corr = bwd[HOUR_W-1:0];
    end
  end

  assign out_valid          = ov_r;
  assign out_summer_time    = out_summer_r;
  assign out_changed        = out_changed_r;
  assign out_corrected_hour = out_hour_r;

  `DST_ASSERT(a_flag_tracks_out, adv_out |=> (flag_r == out_summer_r),
              "summer flag and delivered result disagree")
  `DST_ASSERT(a_hour_passthru, (adv_out && flag_nxt == flag_r) |=> (out_hour_r == $past(s3_hour_r)),
              "hour altered without a flag change")
  `DST_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!ov_r && !v1_r && !v2_r && !v3_r && flag_r),
                     "pipeline not cleared by reset")

endmodule
